[rtl/two_sensor_cooler_thermostat_top_assert.svh]
// Assertion macros for the thermostat RTL.
`ifndef TWO_SENSOR_COOLER_THERMOSTAT_TOP_ASSERT_SVH
`define TWO_SENSOR_COOLER_THERMOSTAT_TOP_ASSERT_SVH

// Clocked check, masked while reset is held.
`define TSCT_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define TSCT_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) (prop)) else $error(msg);

`endif

[rtl/tsct_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tsct_pkg;

  // Samples summed per average.
  localparam logic [1:0] SAMPLES = 2'd3;

  // Fixed thresholds and delays.
  localparam logic signed [11:0] ALARM_ARM_LEVEL  = 12'sd70;
  localparam logic signed [11:0] ALARM_FIRE_LEVEL = 12'sd150;
  localparam logic [31:0]        SAMPLE_PERIOD_MS = 32'd1000;
  localparam logic [31:0]        FAN_DELAY_MS     = 32'd60000;
  localparam logic [9:0]         MS_PER_SECOND    = 10'd1000;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLER_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLATE_LOW_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLATE_HIGH_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLD_LOW_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLD_HIGH_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_OFF_SECONDS  = 3'd5;

  // Cooler command codes.
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_OFF  = 2'd1;
  localparam logic [1:0] CMD_ON   = 2'd2;

  // Reciprocal of three in Q16, exact for magnitudes below 2^15.
  localparam logic [14:0] RECIP_THREE_Q16 = 15'd21846;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_COLLECT = 2'd1,
    PH_FINISH  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic signed [11:0] plate_sample;
    logic signed [11:0] cold_sample;
  } in_item_t;

  typedef struct packed {
    logic               average_valid;
    logic signed [11:0] average_temp;
    logic [1:0]         cooler_command;
    logic               fan_off_pulse;
    logic               alarm_pulse;
  } out_item_t;

  // Signed sum over count, truncated toward zero; zero count gives zero.
  function automatic logic signed [11:0] div_by_count(input logic signed [13:0] sum,
                                                      input logic [1:0] count);
    logic [13:0] mag;
    logic [28:0] prod;
    logic [13:0] quo;
    logic [13:0] res;
    mag  = sum[13] ? 14'(-sum) : 14'(sum);
    prod = 29'(mag) * 29'(RECIP_THREE_Q16);
    case (count)
      2'd1:    quo = mag;
      2'd2:    quo = mag >> 1;
      2'd3:    quo = {1'b0, prod[28:16]};
      default: quo = '0;
    endcase
    res = sum[13] ? 14'(-quo) : quo;
    return res[11:0];
  endfunction

endpackage

`default_nettype wire

[rtl/tsct_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Poll channel: valid/ready with one input item per beat.
interface tsct_in_if import tsct_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Result channel: valid/ready with one result item per beat.
interface tsct_out_if import tsct_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/two_sensor_cooler_thermostat_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Thermostat for a cooled plate: each poll beat (time in ms, plate and
// cold-side temperatures in tenths of a degree) yields exactly one result
// beat through the result register. The whole step is decided in the
// cycle the poll is accepted; the sustained rate is one poll per cycle
// while the output does not stall, set by the result register and a
// one-entry skid register behind it, which together let one more poll in
// while a result waits. Configuration writes take effect on the next cycle
// and belong to idle periods.

`include "two_sensor_cooler_thermostat_top_assert.svh"

module two_sensor_cooler_thermostat_top import tsct_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tsct_in_if.sink                    in_ch,
  tsct_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic               cooler_enable_r;
  logic signed [11:0] plate_low_limit_r;
  logic signed [11:0] plate_high_limit_r;
  logic signed [11:0] cold_low_limit_r;
  logic signed [11:0] cold_high_limit_r;
  logic [25:0]        restart_delay_r;

  // Step state
  phase_t             phase_r, phase_nxt;
  logic [1:0]         sample_count_r, sample_count_nxt;
  logic signed [13:0] sample_sum_r, sample_sum_nxt;
  logic signed [11:0] average_hold_r, average_hold_nxt;
  logic [31:0]        next_deadline_r, next_deadline_nxt;
  logic               alarm_armed_r, alarm_armed_nxt;
  logic               plate_demand_r, plate_demand_nxt;
  logic [31:0]        fan_deadline_r, fan_deadline_nxt;
  logic               fan_pending_r, fan_pending_nxt;
  logic [31:0]        restart_deadline_r, restart_deadline_nxt;
  logic               restart_pending_r, restart_pending_nxt;

  // Result buffering
  out_item_t          result;
  out_item_t          out_data_r, out_data_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          skid_data_r, skid_data_nxt;
  logic               skid_valid_r, skid_valid_nxt;

  logic               in_fire;
  logic [1:0]         count_inc;

  assign in_ch.ready  = !skid_valid_r;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign count_inc    = sample_count_r + 2'd1;

  // Write configuration; keep the restart delay in ms
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cooler_enable_r    <= 1'b0;
      plate_low_limit_r  <= '0;
      plate_high_limit_r <= '0;
      cold_low_limit_r   <= '0;
      cold_high_limit_r  <= '0;
      restart_delay_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COOLER_ENABLE:    cooler_enable_r    <= cfg_wdata[0];
        CFG_PLATE_LOW_LIMIT:  plate_low_limit_r  <= cfg_wdata[11:0];
        CFG_PLATE_HIGH_LIMIT: plate_high_limit_r <= cfg_wdata[11:0];
        CFG_COLD_LOW_LIMIT:   cold_low_limit_r   <= cfg_wdata[11:0];
        CFG_COLD_HIGH_LIMIT:  cold_high_limit_r  <= cfg_wdata[11:0];
        CFG_MIN_OFF_SECONDS:  restart_delay_r    <= 26'(cfg_wdata) * 26'(MS_PER_SECOND);
        default: ;
      endcase
    end
  end

  // Phase next state
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_ch.data.now_ms > next_deadline_r) phase_nxt = PH_COLLECT;
      end
      PH_COLLECT: begin
        if (count_inc >= SAMPLES) phase_nxt = PH_FINISH;
      end
      PH_FINISH: phase_nxt = PH_IDLE;
      default:   phase_nxt = PH_IDLE;
    endcase
  end

  // Step datapath and result
  always_comb begin
    logic               off_v;
    logic               on_v;
    logic signed [11:0] avg_v;
    logic [31:0]        now_v;

    now_v                = in_ch.data.now_ms;
    off_v                = 1'b0;
    on_v                 = 1'b0;
    avg_v                = div_by_count(sample_sum_r, sample_count_r);
    sample_count_nxt     = sample_count_r;
    sample_sum_nxt       = sample_sum_r;
    average_hold_nxt     = average_hold_r;
    next_deadline_nxt    = next_deadline_r;
    alarm_armed_nxt      = alarm_armed_r;
    plate_demand_nxt     = plate_demand_r;
    fan_deadline_nxt     = fan_deadline_r;
    fan_pending_nxt      = fan_pending_r;
    restart_deadline_nxt = restart_deadline_r;
    restart_pending_nxt  = restart_pending_r;
    result               = '0;

    unique case (phase_r)
      PH_IDLE: begin
        if (now_v > next_deadline_r) begin
          sample_count_nxt = '0;
          sample_sum_nxt   = '0;
        end
      end
      PH_COLLECT: begin
        sample_sum_nxt   = sample_sum_r + 14'(in_ch.data.plate_sample);
        sample_count_nxt = count_inc;
      end
      PH_FINISH: begin
        average_hold_nxt  = avg_v;
        result.average_valid = 1'b1;
        next_deadline_nxt = now_v + SAMPLE_PERIOD_MS;

        // Buzzer: arm low, fire once high
        if (avg_v < ALARM_ARM_LEVEL) alarm_armed_nxt = 1'b1;
        if (alarm_armed_nxt && avg_v > ALARM_FIRE_LEVEL) begin
          result.alarm_pulse = 1'b1;
          alarm_armed_nxt    = 1'b0;
        end

        // Fan-off timer expiry
        if (now_v > fan_deadline_r && fan_pending_r) begin
          result.fan_off_pulse = 1'b1;
          fan_pending_nxt      = 1'b0;
        end

        // Plate hysteresis demand
        if (cooler_enable_r) begin
          if (avg_v < plate_low_limit_r) begin
            plate_demand_nxt = 1'b0;
            off_v            = 1'b1;
            fan_deadline_nxt = now_v + FAN_DELAY_MS;
            fan_pending_nxt  = 1'b1;
          end
          if (avg_v > plate_high_limit_r) plate_demand_nxt = 1'b1;
        end

        // Cold-side switch with forced restart
        if (plate_demand_nxt && cooler_enable_r) begin
          if (in_ch.data.cold_sample < cold_low_limit_r) begin
            off_v                = 1'b1;
            restart_deadline_nxt = now_v + 32'(restart_delay_r);
            fan_deadline_nxt     = now_v + FAN_DELAY_MS;
            fan_pending_nxt      = 1'b1;
            restart_pending_nxt  = 1'b1;
          end
          if (in_ch.data.cold_sample > cold_high_limit_r ||
              (now_v > restart_deadline_nxt && restart_pending_nxt)) begin
            on_v            = 1'b1;
            fan_pending_nxt = 1'b0;
          end
        end

        // On wins over off
        result.cooler_command = on_v ? CMD_ON : (off_v ? CMD_OFF : CMD_NONE);
      end
      default: ;
    endcase

    result.average_temp = average_hold_nxt;
  end

  // Commit step state on an accepted poll
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r            <= PH_IDLE;
      sample_count_r     <= '0;
      sample_sum_r       <= '0;
      average_hold_r     <= '0;
      next_deadline_r    <= '0;
      alarm_armed_r      <= 1'b0;
      plate_demand_r     <= 1'b0;
      fan_deadline_r     <= '0;
      fan_pending_r      <= 1'b0;
      restart_deadline_r <= '0;
      restart_pending_r  <= 1'b0;
    end else if (in_fire) begin
      phase_r            <= phase_nxt;
      sample_count_r     <= sample_count_nxt;
      sample_sum_r       <= sample_sum_nxt;
      average_hold_r     <= average_hold_nxt;
      next_deadline_r    <= next_deadline_nxt;
      alarm_armed_r      <= alarm_armed_nxt;
      plate_demand_r     <= plate_demand_nxt;
      fan_deadline_r     <= fan_deadline_nxt;
      fan_pending_r      <= fan_pending_nxt;
      restart_deadline_r <= restart_deadline_nxt;
      restart_pending_r  <= restart_pending_nxt;
    end
  end

  // Result register with skid entry behind it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ch.ready) begin
      // Refill from skid first, else from the new poll
      out_valid_nxt  = skid_valid_r || in_fire;
      out_data_nxt   = skid_valid_r ? skid_data_r : result;
      skid_valid_nxt = 1'b0;
    end else if (in_fire) begin
      // Park the new result while the output stalls
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  `TSCT_ASSERT(a_skid_behind_out, clk, rst_n, skid_valid_r |-> out_valid_r, "skid holds a beat while result register is empty")
  `TSCT_ASSERT(a_pulses_need_avg, clk, rst_n, (out_valid_r && !out_data_r.average_valid) |-> (out_data_r.cooler_command == CMD_NONE && !out_data_r.fan_off_pulse && !out_data_r.alarm_pulse), "command or pulse without a new average")
  `TSCT_ASSERT(a_cmd_code, clk, rst_n, out_valid_r |-> (out_data_r.cooler_command != 2'd3), "reserved cooler command code")
  `TSCT_ASSERT(a_finish_to_idle, clk, rst_n, (in_fire && phase_r == PH_FINISH) |=> (phase_r == PH_IDLE && out_valid_r), "finish step did not return to idle with a result")
  `TSCT_ASSERT_ALWAYS(a_stall_no_accept, clk, (skid_valid_r && out_valid_r) |-> !in_fire, "poll accepted with both result entries full")

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import tsct_pkg::*;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  tsct_in_if  poll_ch ();
  tsct_out_if result_ch ();

  two_sensor_cooler_thermostat_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (poll_ch),
    .out_ch    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Thermostat state as seen from outside, reset values
  phase_t             ph_state      = PH_IDLE;
  int                 acc_count     = 0;
  int                 acc_sum       = 0;
  logic signed [11:0] avg_hold      = '0;
  logic [31:0]        sample_due    = '0;
  bit                 alarm_armed   = 1'b0;
  bit                 demand        = 1'b0;
  logic [31:0]        fan_due       = '0;
  bit                 fan_armed     = 1'b0;
  logic [31:0]        restart_due   = '0;
  bit                 restart_armed = 1'b0;

  // Register settings in effect
  bit          cool_en  = 1'b0;
  int          plate_lo = 0;
  int          plate_hi = 0;
  int          cold_lo  = 0;
  int          cold_hi  = 0;
  logic [15:0] off_secs = '0;

  in_item_t    poll_q[$];
  out_item_t   due_results[$];
  in_item_t    poll_cur;
  bit          poll_busy      = 1'b0;
  int          poll_gap       = 0;
  bit          poll_calm      = 1'b0;
  int          stall_left     = 0;
  bit          sink_calm      = 1'b0;
  int          results_seen   = 0;
  int          mismatch_count = 0;
  logic [31:0] clock_ms       = '0;

  // Advance the thermostat by one poll and return the result it yields
  task automatic thermostat_step(input in_item_t poll, output out_item_t res);
    logic [31:0] now;
    int          plate;
    int          cold;
    int          avg;
    bit          go_off;
    bit          go_on;
    now    = poll.now_ms;
    plate  = $signed(poll.plate_sample);
    cold   = $signed(poll.cold_sample);
    go_off = 1'b0;
    go_on  = 1'b0;
    res    = '0;
    case (ph_state)
      PH_IDLE: begin
        if (now > sample_due) begin
          ph_state  = PH_COLLECT;
          acc_count = 0;
          acc_sum   = 0;
        end
      end
      PH_COLLECT: begin
        acc_sum += plate;
        acc_count++;
        if (acc_count >= int'(SAMPLES)) ph_state = PH_FINISH;
      end
      PH_FINISH: begin
        // SV integer division truncates toward zero
        avg                = acc_sum / acc_count;
        avg_hold           = 12'(avg);
        res.average_valid  = 1'b1;
        ph_state           = PH_IDLE;
        sample_due         = now + SAMPLE_PERIOD_MS;

        // Buzzer: arm when cool, fire once when hot
        if (avg < ALARM_ARM_LEVEL) alarm_armed = 1'b1;
        if (alarm_armed && avg > ALARM_FIRE_LEVEL) begin
          res.alarm_pulse = 1'b1;
          alarm_armed     = 1'b0;
        end

        if (now > fan_due && fan_armed) begin
          res.fan_off_pulse = 1'b1;
          fan_armed         = 1'b0;
        end

        // Plate hysteresis
        if (cool_en) begin
          if (avg < plate_lo) begin
            demand    = 1'b0;
            go_off    = 1'b1;
            fan_due   = now + FAN_DELAY_MS;
            fan_armed = 1'b1;
          end
          if (avg > plate_hi) demand = 1'b1;
        end

        // Cold-side hysteresis and forced restart; the restart mark stays set
        if (demand && cool_en) begin
          if (cold < cold_lo) begin
            go_off        = 1'b1;
            restart_due   = now + off_secs * MS_PER_SECOND;
            fan_due       = now + FAN_DELAY_MS;
            fan_armed     = 1'b1;
            restart_armed = 1'b1;
          end
          if (cold > cold_hi || (now > restart_due && restart_armed)) begin
            go_on     = 1'b1;
            fan_armed = 1'b0;
          end
        end
        res.cooler_command = go_on ? CMD_ON : (go_off ? CMD_OFF : CMD_NONE);
      end
      default: ph_state = PH_IDLE;
    endcase
    res.average_temp = avg_hold;
  endtask

  task automatic flag_field(input string msg);
    $display("ERROR result %0d: %s", results_seen, msg);
    mismatch_count++;
  endtask

  // Drive the poll channel from the pending queue, with random gaps
  always @(posedge clk) begin : drive_polls
    out_item_t want;
    if (!rst_n) begin
      poll_ch.valid <= 1'b0;
      poll_ch.data  <= '0;
    end else begin
      if (poll_ch.valid && poll_ch.ready) begin
        thermostat_step(poll_cur, want);
        due_results.push_back(want);
        poll_busy = 1'b0;
        if ($urandom_range(0, 31) == 0) poll_calm = !poll_calm;
        poll_gap = poll_calm ? 0 : $urandom_range(0, 15);
      end
      if (!poll_busy) begin
        if (poll_gap > 0) begin
          poll_gap--;
        end else if (poll_q.size() > 0) begin
          poll_cur  = poll_q.pop_front();
          poll_busy = 1'b1;
        end
      end
      poll_ch.valid <= poll_busy;
      poll_ch.data  <= poll_cur;
    end
  end

  // Check each result beat against the oldest expectation, stall at random
  always @(posedge clk) begin : check_results
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.data;
        if (due_results.size() == 0) begin
          flag_field("result beat with nothing expected");
        end else begin
          want = due_results.pop_front();
          if (got.average_valid !== want.average_valid)
            flag_field($sformatf("average_valid got %0b want %0b",
                                 got.average_valid, want.average_valid));
          if (got.average_temp !== want.average_temp)
            flag_field($sformatf("average_temp got %0d want %0d",
                                 got.average_temp, want.average_temp));
          if (got.cooler_command !== want.cooler_command)
            flag_field($sformatf("cooler_command got %0d want %0d",
                                 got.cooler_command, want.cooler_command));
          if (got.fan_off_pulse !== want.fan_off_pulse)
            flag_field($sformatf("fan_off_pulse got %0b want %0b",
                                 got.fan_off_pulse, want.fan_off_pulse));
          if (got.alarm_pulse !== want.alarm_pulse)
            flag_field($sformatf("alarm_pulse got %0b want %0b",
                                 got.alarm_pulse, want.alarm_pulse));
        end
        results_seen++;
        if ($urandom_range(0, 31) == 0) sink_calm = !sink_calm;
        stall_left = sink_calm ? 0 : $urandom_range(0, 15);
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  function automatic int clip12(input int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  // Uniform value in -n..n
  function automatic int spread(input int n);
    int v;
    v = $urandom_range(0, 2 * n);
    return v - n;
  endfunction

  // Any 12-bit pattern, sign extended
  function automatic int any_temp();
    logic [11:0] bits;
    bits = 12'($urandom);
    return $signed(bits);
  endfunction

  task automatic push_poll(input logic [31:0] now, input int plate, input int cold);
    in_item_t p;
    p.now_ms       = now;
    p.plate_sample = 12'(plate);
    p.cold_sample  = 12'(cold);
    poll_q.push_back(p);
  endtask

  // One sample round: start poll, three samples, finishing poll.
  // A stray poll may be slipped in before position noise_at.
  task automatic push_round(input logic [31:0] trig, input logic [31:0] fin,
                            input int s0, input int s1, input int s2,
                            input int cold, input int noise_at);
    for (int k = 0; k < 5; k++) begin
      if (k == noise_at) push_poll($urandom_range(fin, 0), any_temp(), any_temp());
      case (k)
        0:       push_poll(trig, any_temp(), any_temp());
        1:       push_poll(trig, s0, any_temp());
        2:       push_poll(trig, s1, any_temp());
        3:       push_poll(trig, s2, any_temp());
        default: push_poll(fin, any_temp(), cold);
      endcase
    end
  endtask

  // Write every register while the block is idle; upper data bits are don't-care
  task automatic program_regs(input bit en, input int p_lo, input int p_hi,
                              input int c_lo, input int c_hi, input logic [15:0] secs);
    logic [CFG_IDX_W-1:0] idx[6];
    logic [15:0]          val[6];
    idx    = '{CFG_COOLER_ENABLE, CFG_PLATE_LOW_LIMIT, CFG_PLATE_HIGH_LIMIT,
               CFG_COLD_LOW_LIMIT, CFG_COLD_HIGH_LIMIT, CFG_MIN_OFF_SECONDS};
    val[0] = {15'($urandom), en};
    val[1] = {4'($urandom), 12'(p_lo)};
    val[2] = {4'($urandom), 12'(p_hi)};
    val[3] = {4'($urandom), 12'(c_lo)};
    val[4] = {4'($urandom), 12'(c_hi)};
    val[5] = secs;
    for (int i = 0; i < 6; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
    end
    @(posedge clk);
    cfg_we   <= 1'b0;
    cool_en  = en;
    plate_lo = p_lo;
    plate_hi = p_hi;
    cold_lo  = c_lo;
    cold_hi  = c_hi;
    off_secs = secs;
  endtask

  // Hold until every poll is taken and every result has come back
  task automatic wait_quiet();
    while (poll_q.size() != 0 || poll_busy || due_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Queue sample rounds with advancing time until about target polls
  task automatic fill_random(input int target);
    int          counted;
    int          step;
    int          centre;
    int          cold;
    int          s[3];
    logic [32:0] ahead;
    logic [31:0] trig;
    logic [31:0] fin;
    counted = 0;
    while (counted < target) begin
      // Poll that lands before the deadline
      if ($urandom_range(0, 6) == 0) push_poll(clock_ms, any_temp(), any_temp());

      case ($urandom_range(0, 19))
        0:       step = $urandom_range(60000, 200000);
        1:       step = $urandom_range(1000000, 70000000);
        default: step = $urandom_range(1001, 3000);
      endcase
      ahead = {1'b0, clock_ms} + 33'(step);
      if (ahead[32]) begin
        // Cross the wrap: start at the top so the old deadline is passed
        trig = '1;
        fin  = ahead[31:0];
      end else begin
        trig = ahead[31:0];
        fin  = trig + $urandom_range(0, 40);
      end
      clock_ms = fin;

      case ($urandom_range(0, 5))
        0:       centre = plate_lo;
        1:       centre = plate_hi;
        2:       centre = ALARM_ARM_LEVEL;
        3:       centre = ALARM_FIRE_LEVEL;
        default: centre = spread(2000);
      endcase
      centre += spread(30);
      for (int i = 0; i < 3; i++) begin
        s[i] = ($urandom_range(0, 49) == 0) ? any_temp() : clip12(centre + spread(20));
      end

      case ($urandom_range(0, 4))
        0, 1:    cold = clip12(cold_lo + spread(30));
        2, 3:    cold = clip12(cold_hi + spread(30));
        default: cold = spread(2000);
      endcase

      push_round(trig, fin, s[0], s[1], s[2], cold,
                 ($urandom_range(0, 11) == 0) ? $urandom_range(0, 4) : -1);
      counted += 5;
    end
  endtask

  initial begin
    poll_ch.valid   = 1'b0;
    poll_ch.data    = '0;
    result_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    program_regs(1'b1, 100, 200, -50, 50, 16'd2);

    // Equal to the deadline: no start
    push_poll(32'd0, 0, 0);
    // Coldest plate: alarm arms, demand drops, cooler off
    push_round(32'd1, 32'd1, -2048, -2048, -2048, 2047, -1);
    // Hottest plate: alarm fires, demand starts, cold side low turns cooler off
    push_round(32'd1200, 32'd1200, 2047, 2047, 2047, -2048, -1);
    // Cold side high and restart overdue: cooler on
    push_round(32'd5000, 32'd5000, 150, 151, 152, 2047, -1);
    // Off and on together near the top of time; restart deadline wraps
    push_round(32'hFFFF_FF00, 32'hFFFF_FF00, 200, 200, 201, -2048, -1);
    // Negative sum truncates toward zero; sample and fan deadlines wrap
    push_round(32'hFFFF_FFFF, 32'hFFFF_FFFF, -1, -1, -2, 0, -1);
    // Wrapped sample deadline: equal does not start, one more does
    push_poll(32'd999, 0, 0);
    push_poll(32'd1000, 0, 0);
    clock_ms = 32'd1000;

    for (int ph = 0; ph < 6; ph++) begin
      wait_quiet();
      case (ph)
        0: program_regs(1'b1, -300, 100, -200, 200, 16'($urandom_range(0, 5)));
        1: program_regs(1'b1, -2000, 2000, -2000, 2000, 16'd65535);
        2: program_regs(1'b0, spread(300), spread(300), spread(300), spread(300),
                        16'($urandom_range(0, 5)));
        3: program_regs(1'b1, 2000, -2000, 2000, -2000, 16'd0);
        4: begin
          program_regs(1'b1, spread(2000), spread(2000), spread(2000), spread(2000),
                       16'($urandom));
          // Run across the top of the ms counter
          clock_ms = 32'hFFFF_C000;
        end
        default: program_regs(1'b1, spread(200), spread(200) + 150, -100 - spread(50),
                              100 + spread(50), 16'd0);
      endcase
      fill_random(150);
    end

    wait_quiet();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
